@@ rtl/betq_pkg.sv @@
// Shared types and constants for the bulk endpoint transfer queue.
package betq_pkg;

  localparam logic [3:0] REQ_TX_SUBMIT   = 4'd0;
  localparam logic [3:0] REQ_RX_ARM      = 4'd1;
  localparam logic [3:0] REQ_IN_SENT     = 4'd2;
  localparam logic [3:0] REQ_OUT_RCVD    = 4'd3;
  localparam logic [3:0] REQ_STALL_IN    = 4'd4;
  localparam logic [3:0] REQ_STALL_OUT   = 4'd5;
  localparam logic [3:0] REQ_FLUSH       = 4'd6;
  localparam logic [3:0] REQ_CLR_HALT_IN = 4'd7;
  localparam logic [3:0] REQ_CLR_HALT_OUT = 4'd8;

  localparam logic [1:0] RESP_NONE  = 2'd0;
  localparam logic [1:0] RESP_NAK   = 2'd1;
  localparam logic [1:0] RESP_ACK   = 2'd2;
  localparam logic [1:0] RESP_STALL = 2'd3;

  localparam logic [10:0] MPL_RESET = 11'd512;
  localparam logic [10:0] MPL_MIN   = 11'd8;
  localparam logic [10:0] MPL_MAX   = 11'd1024;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [31:0] buf_addr;
    logic [23:0] xfer_len;
    logic [10:0] rx_len;
    logic        toggle_match;
  } req_item_t;

  typedef struct packed {
    logic        tx_program;
    logic [31:0] tx_dma_addr;
    logic [10:0] tx_pkt_len;
    logic [1:0]  tx_response;
    logic        rx_program;
    logic [31:0] rx_dma_addr;
    logic [1:0]  rx_response;
    logic        rx_done;
    logic [31:0] rx_done_buf;
    logic [24:0] rx_done_count;
    logic        tx_done;
    logic        accepted;
  } rsp_item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
    logic set_done;
  } queue_cmd_t;

endpackage

@@ rtl/betq_if.sv @@
// Valid/ready channel interfaces for request and result beats.
interface betq_req_if;
  import betq_pkg::*;
  logic      valid;
  logic      ready;
  req_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface betq_rsp_if;
  import betq_pkg::*;
  logic      valid;
  logic      ready;
  rsp_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ rtl/betq_queue.sv @@
// Shifting buffer queue: head always sits in entry 0.
module betq_queue #(
  parameter int DEPTH    = 2,
  parameter int LEN_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  betq_pkg::queue_cmd_t           cmd,
  input  logic [31:0]                    push_addr,
  input  logic [LEN_BITS-1:0]            push_len,
  input  logic [LEN_BITS:0]              done_val,
  output logic [$clog2(DEPTH+1)-1:0]     count,
  output logic [31:0]                    head_addr,
  output logic [LEN_BITS-1:0]            head_len,
  output logic [LEN_BITS:0]              head_done,
  output logic [31:0]                    next_addr,
  output logic [LEN_BITS-1:0]            next_len,
  output logic [LEN_BITS:0]              next_done
);
  import betq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [31:0]         e_addr [DEPTH];
  logic [LEN_BITS-1:0] e_len  [DEPTH];
  logic [LEN_BITS:0]   e_done [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_entry
    logic [31:0]         up_addr;
    logic [LEN_BITS-1:0] up_len;
    logic [LEN_BITS:0]   up_done;

    if (i < DEPTH - 1) begin : g_up
      assign up_addr = e_addr[i+1];
      assign up_len  = e_len[i+1];
      assign up_done = e_done[i+1];
    end else begin : g_top
      assign up_addr = e_addr[i];
      assign up_len  = e_len[i];
      assign up_done = e_done[i];
    end

    always_ff @(posedge clk) begin
      if (cmd.pop) begin
        e_addr[i] <= up_addr;
        e_len[i]  <= up_len;
        e_done[i] <= up_done;
      end else if (cmd.push && count == CW'(i)) begin
        e_addr[i] <= push_addr;
        e_len[i]  <= push_len;
        e_done[i] <= '0;
      end else if (cmd.set_done && i == 0) begin
        e_done[i] <= done_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.push) begin
      count <= count + CW'(1);
    end else if (cmd.pop) begin
      count <= count - CW'(1);
    end
  end

  assign head_addr = e_addr[0];
  assign head_len  = e_len[0];
  assign head_done = e_done[0];
  assign next_addr = e_addr[1];
  assign next_len  = e_len[1];
  assign next_done = e_done[1];

endmodule

@@ rtl/bulk_endpoint_transfer_queue.sv @@
// Top level: bulk IN/OUT transfer engine with per-direction buffer queues.
//
//   channel | dir | handshake     | beat
//   req     | in  | valid/ready   | one endpoint event
//   rsp     | out | valid/ready   | one result per event
//   cfg     | in  | cfg_we        | max_packet_len write
//
// An event is captured in an input register and resolved in one pass into the
// result register: one event per cycle while rsp is not stalling.
// The queue update (add and compare on the head entry) is done in that one pass.
// rsp stalls back up only through the two registers; req keeps flowing while
// the result register drains. Synchronous reset empties both queues.
module bulk_endpoint_transfer_queue #(
  parameter int QUEUE_DEPTH = 2,
  parameter int LEN_BITS    = 24
) (
  input  logic        clk,
  input  logic        rst,
  betq_req_if.sink    req,
  betq_rsp_if.source  rsp,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata
);
  import betq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int DW = LEN_BITS + 1;

  logic [10:0] max_packet_len;
  logic [10:0] mpl;
  logic [10:0] current_piece_len;
  logic [10:0] piece_next;

  req_item_t in_q;
  logic      in_valid;
  rsp_item_t out_q;
  logic      out_valid;
  rsp_item_t res;
  logic      process;

  queue_cmd_t tx_cmd, rx_cmd, tx_cmd_en, rx_cmd_en;
  logic [DW-1:0] tx_done_val, rx_done_val;

  logic [CW-1:0]       tx_count, rx_count;
  logic [31:0]         tx_h_addr, tx_n_addr, rx_h_addr, rx_n_addr;
  logic [LEN_BITS-1:0] tx_h_len, tx_n_len, rx_h_len, rx_n_len;
  logic [DW-1:0]       tx_h_done, tx_n_done, rx_h_done, rx_n_done;

  logic [LEN_BITS-1:0] xlen;
  logic [DW-1:0]       tx_sum, rx_sum;

  // piece source select
  logic                send;
  logic [31:0]         src_addr;
  logic [LEN_BITS-1:0] src_len;
  logic [DW-1:0]       src_done;
  logic [DW-1:0]       rem;

  assign process   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || process;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet_len <= MPL_RESET;
    end else if (cfg_we) begin
      max_packet_len <= cfg_wdata;
    end
  end

  assign mpl = (max_packet_len < MPL_MIN) ? MPL_MIN :
               (max_packet_len > MPL_MAX) ? MPL_MAX : max_packet_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_q <= req.data;
    end
  end

  assign xlen   = LEN_BITS'(in_q.xfer_len);
  assign tx_sum = tx_h_done + DW'(current_piece_len);
  assign rx_sum = rx_h_done + DW'(in_q.rx_len);

  always_comb begin
    res         = '0;
    tx_cmd      = '0;
    rx_cmd      = '0;
    tx_done_val = '0;
    rx_done_val = '0;
    send        = 1'b0;
    src_addr    = tx_h_addr;
    src_len     = tx_h_len;
    src_done    = tx_h_done;
    piece_next  = current_piece_len;

    case (in_q.req_type)
      REQ_TX_SUBMIT: begin
        if (tx_count != CW'(QUEUE_DEPTH)) begin
          tx_cmd.push  = 1'b1;
          res.accepted = 1'b1;
          if (tx_count == '0) begin
            send     = 1'b1;
            src_addr = in_q.buf_addr;
            src_len  = xlen;
            src_done = '0;
          end
        end
      end
      REQ_RX_ARM: begin
        if (rx_count != CW'(QUEUE_DEPTH)) begin
          rx_cmd.push  = 1'b1;
          res.accepted = 1'b1;
          if (rx_count == '0) begin
            res.rx_program  = 1'b1;
            res.rx_dma_addr = in_q.buf_addr;
            res.rx_response = RESP_ACK;
          end
        end
      end
      REQ_IN_SENT: begin
        res.tx_response = RESP_NAK;
        if (tx_count != '0) begin
          if (tx_sum < DW'(tx_h_len)) begin
            tx_cmd.set_done = 1'b1;
            tx_done_val     = tx_sum;
            send            = 1'b1;
            src_done        = tx_sum;
          end else begin
            tx_cmd.pop  = 1'b1;
            res.tx_done = 1'b1;
            if (tx_count > CW'(1)) begin
              send     = 1'b1;
              src_addr = tx_n_addr;
              src_len  = tx_n_len;
              src_done = tx_n_done;
            end
          end
        end
      end
      REQ_OUT_RCVD: begin
        if (!in_q.toggle_match) begin
          // wrong toggle: host retried a packet already taken
          res.rx_response = RESP_ACK;
        end else begin
          res.rx_response = RESP_NAK;
          if (rx_count != '0) begin
            if (rx_sum >= DW'(rx_h_len) || in_q.rx_len < mpl) begin
              rx_cmd.pop        = 1'b1;
              res.rx_done       = 1'b1;
              res.rx_done_buf   = rx_h_addr;
              res.rx_done_count = 25'(rx_sum);
              if (rx_count > CW'(1)) begin
                res.rx_program  = 1'b1;
                res.rx_dma_addr = rx_n_addr;
                res.rx_response = RESP_ACK;
              end
            end else begin
              rx_cmd.set_done = 1'b1;
              rx_done_val     = rx_sum;
              res.rx_program  = 1'b1;
              res.rx_dma_addr = rx_h_addr + 32'(rx_sum);
              res.rx_response = RESP_ACK;
            end
          end
        end
      end
      REQ_STALL_IN: begin
        tx_cmd.clear    = 1'b1;
        res.tx_response = RESP_STALL;
      end
      REQ_STALL_OUT: begin
        rx_cmd.clear    = 1'b1;
        res.rx_response = RESP_STALL;
      end
      REQ_FLUSH: begin
        tx_cmd.clear    = 1'b1;
        rx_cmd.clear    = 1'b1;
        piece_next      = '0;
        res.tx_response = RESP_NAK;
        res.rx_response = RESP_NAK;
      end
      REQ_CLR_HALT_IN: begin
        res.tx_response = RESP_NAK;
        if (tx_count != '0) begin
          tx_cmd.set_done = 1'b1;
          send            = 1'b1;
          src_done        = '0;
        end
      end
      REQ_CLR_HALT_OUT: begin
        res.rx_response = RESP_NAK;
        if (rx_count != '0) begin
          rx_cmd.set_done = 1'b1;
          res.rx_program  = 1'b1;
          res.rx_dma_addr = rx_h_addr;
          res.rx_response = RESP_ACK;
        end
      end
      default: begin
      end
    endcase

    // next IN piece: remaining bytes capped at the packet size
    rem = (src_done < DW'(src_len)) ? DW'(src_len) - src_done : '0;
    if (send) begin
      res.tx_program  = 1'b1;
      res.tx_dma_addr = src_addr + 32'(src_done);
      res.tx_pkt_len  = (rem > DW'(mpl)) ? mpl : 11'(rem);
      res.tx_response = RESP_ACK;
      piece_next      = res.tx_pkt_len;
    end
  end

  assign tx_cmd_en = process ? tx_cmd : '0;
  assign rx_cmd_en = process ? rx_cmd : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_piece_len <= '0;
    end else if (process) begin
      current_piece_len <= piece_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      out_q <= res;
    end
  end

  betq_queue #(
    .DEPTH    (QUEUE_DEPTH),
    .LEN_BITS (LEN_BITS)
  ) u_tx_queue (
    .clk       (clk),
    .rst       (rst),
    .cmd       (tx_cmd_en),
    .push_addr (in_q.buf_addr),
    .push_len  (xlen),
    .done_val  (tx_done_val),
    .count     (tx_count),
    .head_addr (tx_h_addr),
    .head_len  (tx_h_len),
    .head_done (tx_h_done),
    .next_addr (tx_n_addr),
    .next_len  (tx_n_len),
    .next_done (tx_n_done)
  );

  betq_queue #(
    .DEPTH    (QUEUE_DEPTH),
    .LEN_BITS (LEN_BITS)
  ) u_rx_queue (
    .clk       (clk),
    .rst       (rst),
    .cmd       (rx_cmd_en),
    .push_addr (in_q.buf_addr),
    .push_len  (xlen),
    .done_val  (rx_done_val),
    .count     (rx_count),
    .head_addr (rx_h_addr),
    .head_len  (rx_h_len),
    .head_done (rx_h_done),
    .next_addr (rx_n_addr),
    .next_len  (rx_n_len),
    .next_done (rx_n_done)
  );

endmodule

@@ tb/sv/betq_transfer_checker.sv @@
// Checker for the bulk endpoint transfer queue: predicts each result beat and compares it.
module betq_transfer_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_ready,
  input  betq_pkg::req_item_t req_data,
  input  logic                rsp_valid,
  input  logic                rsp_ready,
  input  betq_pkg::rsp_item_t rsp_data,
  input  logic                cfg_we,
  input  logic [10:0]         cfg_wdata,
  output int unsigned         mismatches,
  output int                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import betq_pkg::*;

  localparam int DEPTH = 2;

  // queue entries, per direction
  logic [31:0] tx_addr_q [DEPTH];
  logic [23:0] tx_len_q  [DEPTH];
  logic [24:0] tx_done_q [DEPTH];
  logic [31:0] rx_addr_q [DEPTH];
  logic [23:0] rx_len_q  [DEPTH];
  logic [24:0] rx_done_q [DEPTH];
  // pointers count modulo twice the depth
  logic [1:0]  tx_wp, tx_rp, rx_wp, rx_rp;
  logic [10:0] piece_len;
  logic [10:0] mpl_reg;

  rsp_item_t   expected_rsp [$];
  rsp_item_t   want;

  function automatic logic [10:0] packet_limit();
    if (mpl_reg < MPL_MIN) return MPL_MIN;
    if (mpl_reg > MPL_MAX) return MPL_MAX;
    return mpl_reg;
  endfunction

  function automatic void load_in_piece(input logic slot, inout rsp_item_t r);
    logic [24:0] remain;
    logic [10:0] pkt;
    remain = (tx_done_q[slot] < {1'b0, tx_len_q[slot]}) ?
             {1'b0, tx_len_q[slot]} - tx_done_q[slot] : 25'd0;
    pkt = (remain > {14'd0, packet_limit()}) ? packet_limit() : remain[10:0];
    piece_len     = pkt;
    r.tx_program  = 1'b1;
    r.tx_dma_addr = tx_addr_q[slot] + {7'd0, tx_done_q[slot]};
    r.tx_pkt_len  = pkt;
    r.tx_response = RESP_ACK;
  endfunction

  function automatic rsp_item_t resolve_event(input req_item_t it);
    rsp_item_t  r;
    logic [1:0] fill;
    logic       slot;
    r = '0;
    case (it.req_type)
      REQ_TX_SUBMIT: begin
        fill = tx_wp - tx_rp;
        if (fill < 2'(DEPTH)) begin
          slot            = tx_wp[0];
          tx_addr_q[slot] = it.buf_addr;
          tx_len_q[slot]  = it.xfer_len;
          tx_done_q[slot] = '0;
          tx_wp           = tx_wp + 2'd1;
          r.accepted      = 1'b1;
          fill            = tx_wp - tx_rp;
          if (fill == 2'd1) load_in_piece(slot, r);
        end
      end
      REQ_RX_ARM: begin
        fill = rx_wp - rx_rp;
        if (fill < 2'(DEPTH)) begin
          slot            = rx_wp[0];
          rx_addr_q[slot] = it.buf_addr;
          rx_len_q[slot]  = it.xfer_len;
          rx_done_q[slot] = '0;
          rx_wp           = rx_wp + 2'd1;
          r.accepted      = 1'b1;
          fill            = rx_wp - rx_rp;
          if (fill == 2'd1) begin
            r.rx_program  = 1'b1;
            r.rx_dma_addr = it.buf_addr;
            r.rx_response = RESP_ACK;
          end
        end
      end
      REQ_IN_SENT: begin
        r.tx_response = RESP_NAK;
        if (tx_rp != tx_wp) begin
          slot            = tx_rp[0];
          tx_done_q[slot] = tx_done_q[slot] + {14'd0, piece_len};
          if (tx_done_q[slot] < {1'b0, tx_len_q[slot]}) begin
            load_in_piece(slot, r);
          end else begin
            tx_rp     = tx_rp + 2'd1;
            r.tx_done = 1'b1;
            if (tx_rp != tx_wp) load_in_piece(tx_rp[0], r);
          end
        end
      end
      REQ_OUT_RCVD: begin
        if (!it.toggle_match) begin
          // data toggle mismatch: just ack the retry
          r.rx_response = RESP_ACK;
        end else begin
          r.rx_response = RESP_NAK;
          if (rx_rp != rx_wp) begin
            slot            = rx_rp[0];
            rx_done_q[slot] = rx_done_q[slot] + {14'd0, it.rx_len};
            if (rx_done_q[slot] >= {1'b0, rx_len_q[slot]} || it.rx_len < packet_limit()) begin
              r.rx_done       = 1'b1;
              r.rx_done_buf   = rx_addr_q[slot];
              r.rx_done_count = rx_done_q[slot];
              rx_rp           = rx_rp + 2'd1;
              if (rx_rp != rx_wp) begin
                r.rx_program  = 1'b1;
                r.rx_dma_addr = rx_addr_q[rx_rp[0]];
                r.rx_response = RESP_ACK;
              end
            end else begin
              r.rx_program  = 1'b1;
              r.rx_dma_addr = rx_addr_q[slot] + {7'd0, rx_done_q[slot]};
              r.rx_response = RESP_ACK;
            end
          end
        end
      end
      REQ_STALL_IN: begin
        tx_wp         = '0;
        tx_rp         = '0;
        r.tx_response = RESP_STALL;
      end
      REQ_STALL_OUT: begin
        rx_wp         = '0;
        rx_rp         = '0;
        r.rx_response = RESP_STALL;
      end
      REQ_FLUSH: begin
        tx_wp         = '0;
        tx_rp         = '0;
        rx_wp         = '0;
        rx_rp         = '0;
        piece_len     = '0;
        r.tx_response = RESP_NAK;
        r.rx_response = RESP_NAK;
      end
      REQ_CLR_HALT_IN: begin
        r.tx_response = RESP_NAK;
        if (tx_rp != tx_wp) begin
          tx_done_q[tx_rp[0]] = '0;
          load_in_piece(tx_rp[0], r);
        end
      end
      REQ_CLR_HALT_OUT: begin
        r.rx_response = RESP_NAK;
        if (rx_rp != rx_wp) begin
          rx_done_q[rx_rp[0]] = '0;
          r.rx_program        = 1'b1;
          r.rx_dma_addr       = rx_addr_q[rx_rp[0]];
          r.rx_response       = RESP_ACK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mpl_reg    = MPL_RESET;
      tx_wp      = '0;
      tx_rp      = '0;
      rx_wp      = '0;
      rx_rp      = '0;
      piece_len  = '0;
      mismatches = 0;
      expected_rsp.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          $error("result beat with no event outstanding");
          mismatches++;
        end else begin
          want = expected_rsp.pop_front();
          check_field("tx_program", want.tx_program, rsp_data.tx_program);
          check_field("tx_dma_addr", want.tx_dma_addr, rsp_data.tx_dma_addr);
          check_field("tx_pkt_len", want.tx_pkt_len, rsp_data.tx_pkt_len);
          check_field("tx_response", want.tx_response, rsp_data.tx_response);
          check_field("rx_program", want.rx_program, rsp_data.rx_program);
          check_field("rx_dma_addr", want.rx_dma_addr, rsp_data.rx_dma_addr);
          check_field("rx_response", want.rx_response, rsp_data.rx_response);
          check_field("rx_done", want.rx_done, rsp_data.rx_done);
          check_field("rx_done_buf", want.rx_done_buf, rsp_data.rx_done_buf);
          check_field("rx_done_count", want.rx_done_count, rsp_data.rx_done_count);
          check_field("tx_done", want.tx_done, rsp_data.tx_done);
          check_field("accepted", want.accepted, rsp_data.accepted);
        end
      end
      // cfg writes only land while idle, so no event shares their edge
      if (cfg_we) mpl_reg = cfg_wdata;
      if (req_valid && req_ready) expected_rsp.push_back(resolve_event(req_data));
    end
    outstanding = expected_rsp.size();
  end

endmodule

@@ tb/sv/bulk_endpoint_transfer_queue_test.sv @@
// Testbench top for the bulk endpoint transfer queue: clock, reset, stimulus and verdict.
module bulk_endpoint_transfer_queue_test;
  timeunit 1ns;
  timeprecision 1ps;
  import betq_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int          SEG_ITEMS    = 150;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [10:0] cfg_wdata;
  int unsigned mismatches;
  int          outstanding;
  int          src_idle;
  int          sink_idle;
  logic [10:0] cur_mpl;
  int unsigned cycle_count;

  betq_req_if req_ch ();
  betq_rsp_if rsp_ch ();

  bulk_endpoint_transfer_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  betq_transfer_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_ch.valid),
    .req_ready   (req_ch.ready),
    .req_data    (req_ch.data),
    .rsp_valid   (rsp_ch.valid),
    .rsp_ready   (rsp_ch.ready),
    .rsp_data    (rsp_ch.data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= sink_idle);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("bulk_endpoint_transfer_queue regression: fail");
    $finish;
  end

  function automatic req_item_t mk(input logic [3:0] kind, input logic [31:0] addr,
                                   input logic [23:0] len, input logic [10:0] rlen,
                                   input logic tm);
    req_item_t it;
    it.req_type     = kind;
    it.buf_addr     = addr;
    it.xfer_len     = len;
    it.rx_len       = rlen;
    it.toggle_match = tm;
    return it;
  endfunction

  // mostly well-formed traffic: transfers a few packets long, full or short OUT packets
  function automatic req_item_t random_event();
    req_item_t   it;
    int          pick;
    int          sel;
    logic [10:0] lim;
    lim = (cur_mpl < MPL_MIN) ? MPL_MIN : (cur_mpl > MPL_MAX) ? MPL_MAX : cur_mpl;
    it.buf_addr     = ($urandom_range(7) == 0) ? {24'hFFFFFF, 8'($urandom)} : $urandom;
    it.xfer_len     = 24'($urandom);
    it.rx_len       = 11'($urandom_range(1024));
    it.toggle_match = 1'($urandom_range(1));
    pick = $urandom_range(99);
    sel  = $urandom_range(9);
    if (pick < 16) begin
      it.req_type = REQ_TX_SUBMIT;
      if (sel == 0) it.xfer_len = '0;
      else if (sel != 1) it.xfer_len = 24'($urandom_range(3 * lim));
    end else if (pick < 32) begin
      it.req_type = REQ_RX_ARM;
      if (sel == 0) it.xfer_len = '0;
      else if (sel != 1) it.xfer_len = 24'($urandom_range(4 * lim));
    end else if (pick < 58) begin
      it.req_type = REQ_IN_SENT;
    end else if (pick < 84) begin
      it.req_type     = REQ_OUT_RCVD;
      it.toggle_match = ($urandom_range(9) != 0);
      if (sel < 5) it.rx_len = lim;
      else if (sel < 8) it.rx_len = 11'($urandom_range(lim - 1));
    end else if (pick < 87) begin
      it.req_type = REQ_STALL_IN;
    end else if (pick < 90) begin
      it.req_type = REQ_STALL_OUT;
    end else if (pick < 92) begin
      it.req_type = REQ_FLUSH;
    end else if (pick < 95) begin
      it.req_type = REQ_CLR_HALT_IN;
    end else if (pick < 98) begin
      it.req_type = REQ_CLR_HALT_OUT;
    end else begin
      it.req_type = 4'($urandom_range(9, 15));
    end
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_beat(input req_item_t it);
    while ($urandom_range(99) < src_idle) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= it;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_mpl(input logic [10:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we  <= 1'b0;
    cur_mpl = value;
    @(negedge clk);
  endtask

  logic [10:0] mpl_plan [9] = '{11'd1024, 11'd8, 11'd2047, 11'd64, 11'd0,
                                11'd512, 11'd13, 11'd1000, 11'd100};

  initial begin
    req_item_t it;
    int        counted;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    src_idle     = 6;
    sink_idle    = 78;
    cur_mpl      = MPL_RESET;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty queues: handshake only
    send_beat(mk(REQ_IN_SENT, '0, '0, '0, 1'b0));
    send_beat(mk(REQ_OUT_RCVD, '0, '0, 11'd512, 1'b1));
    send_beat(mk(REQ_OUT_RCVD, '0, '0, 11'd512, 1'b0));
    send_beat(mk(REQ_CLR_HALT_IN, '0, '0, '0, 1'b0));
    // zero-length IN transfer at the top of the address space
    send_beat(mk(REQ_TX_SUBMIT, 32'hFFFF_FFFF, '0, '0, 1'b0));
    send_beat(mk(REQ_IN_SENT, '0, '0, '0, 1'b0));
    // multi-piece transfer that wraps the address, then a full queue
    send_beat(mk(REQ_TX_SUBMIT, 32'hFFFF_FE00, 24'd1200, '0, 1'b0));
    send_beat(mk(REQ_TX_SUBMIT, 32'h0000_1000, 24'd5, '0, 1'b0));
    send_beat(mk(REQ_TX_SUBMIT, 32'h0000_2000, 24'hFF_FFFF, '0, 1'b0));
    repeat (4) send_beat(mk(REQ_IN_SENT, '0, '0, '0, 1'b0));
    // OUT side: toggle retry, full buffer, overrun, clear halt, short packet
    send_beat(mk(REQ_RX_ARM, 32'h8000_0000, 24'd1024, '0, 1'b0));
    send_beat(mk(REQ_RX_ARM, 32'hFFFF_FFF0, 24'hFF_FFFF, '0, 1'b0));
    send_beat(mk(REQ_RX_ARM, 32'h1234_5678, 24'd64, '0, 1'b0));
    send_beat(mk(REQ_OUT_RCVD, '0, '0, 11'd512, 1'b0));
    send_beat(mk(REQ_OUT_RCVD, '0, '0, 11'd512, 1'b1));
    send_beat(mk(REQ_OUT_RCVD, '0, '0, 11'd1024, 1'b1));
    send_beat(mk(REQ_OUT_RCVD, '0, '0, 11'd1024, 1'b1));
    send_beat(mk(REQ_CLR_HALT_OUT, '0, '0, '0, 1'b0));
    send_beat(mk(REQ_OUT_RCVD, '0, '0, 11'd7, 1'b1));
    // halts and flush with work queued
    send_beat(mk(REQ_TX_SUBMIT, 32'h0, 24'hFF_FFFF, '0, 1'b0));
    send_beat(mk(REQ_IN_SENT, '0, '0, '0, 1'b0));
    send_beat(mk(REQ_CLR_HALT_IN, '0, '0, '0, 1'b0));
    send_beat(mk(REQ_STALL_IN, '0, '0, '0, 1'b0));
    send_beat(mk(REQ_RX_ARM, 32'h4000_0000, 24'd100, '0, 1'b0));
    send_beat(mk(REQ_STALL_OUT, '0, '0, '0, 1'b0));
    send_beat(mk(REQ_FLUSH, '0, '0, '0, 1'b0));
    send_beat(mk(4'hF, 32'hFFFF_FFFF, 24'hFF_FFFF, 11'd1024, 1'b1));

    for (int seg = 0; seg < 9; seg++) begin
      if (seg / 3 == 0) begin
        src_idle  = 6;
        sink_idle = 78;
      end else if (seg / 3 == 1) begin
        src_idle  = 78;
        sink_idle = 6;
      end else begin
        src_idle  = 0;
        sink_idle = 0;
      end
      write_mpl((seg == 8) ? 11'($urandom) : mpl_plan[seg]);
      counted = 0;
      while (counted < SEG_ITEMS) begin
        it = random_event();
        send_beat(it);
        if (it.req_type <= REQ_CLR_HALT_OUT) counted++;
      end
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("bulk_endpoint_transfer_queue regression: pass");
    end else begin
      $display("bulk_endpoint_transfer_queue regression: fail");
    end
    $finish;
  end

endmodule
